[design/case_folding_superfast_hash_unit_defines.svh]
// Assertion macros shared by the hash unit RTL.
`ifndef CASE_FOLDING_SUPERFAST_HASH_UNIT_DEFINES_SVH
`define CASE_FOLDING_SUPERFAST_HASH_UNIT_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define CFSH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define CFSH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/cfsh_pkg.sv]
package cfsh_pkg;

  localparam int unsigned IN_TDATA_W = 72;
  localparam int unsigned HASH_W     = 32;

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;

  localparam logic [2:0] COUNT_FULL  = 3'd4;
  localparam logic [2:0] COUNT_THREE = 3'd3;
  localparam logic [2:0] COUNT_TWO   = 3'd2;
  localparam logic [2:0] COUNT_ONE   = 3'd1;

  typedef struct packed {
    logic        first;
    logic [30:0] message_length;
    logic [31:0] chunk;
    logic [2:0]  byte_count;
    logic        last;
  } item_t;

  // Lower-case fold, then sign-extend as a signed char.
  function automatic logic [31:0] fold_ext(input logic [7:0] b);
    logic [7:0] v;
    v = b;
    if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) begin
      v = b + CASE_OFFSET;
    end
    return {{24{v[7]}}, v};
  endfunction

  // 256 * first + second, on the sign-extended bytes.
  function automatic logic [31:0] half_word(input logic [15:0] pair);
    logic [31:0] hi;
    logic [31:0] lo;
    hi = fold_ext(pair[7:0]);
    lo = fold_ext(pair[15:8]);
    return (hi << 8) + lo;
  endfunction

endpackage

[design/case_folding_superfast_hash_unit.sv]
// A last word moves from the input register to the avalanche register to m_tdata.
// Throughput: one word per cycle; only a last word can wait on a stalled output.
// Stages: input register, round into the accumulator, avalanche register, output.
// Reset (rst, synchronous, active high): clears the accumulator and all valid flags.
`include "case_folding_superfast_hash_unit_defines.svh"

module case_folding_superfast_hash_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // [30:0] message_length, [62:31] chunk, [65:63] byte_count, [71:66] zero
  input  logic [cfsh_pkg::IN_TDATA_W-1:0] s_tdata,
  // [0] first
  input  logic                            s_tuser,
  input  logic                            s_tlast,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [31:0] hash_value
  output logic [cfsh_pkg::HASH_W-1:0]     m_tdata
);
  import cfsh_pkg::*;

  item_t       in_item;
  item_t       a_item;
  logic        a_valid;
  logic [31:0] acc;
  logic [31:0] round_hash;
  logic        b_valid;
  logic [31:0] b_hash;
  logic [31:0] aval_hash;
  logic        out_free;
  logic        b_free;
  logic        b_fire;
  logic        a_out_ok;
  logic        s_fire;

  always_comb begin
    in_item.first          = s_tuser;
    in_item.message_length = s_tdata[30:0];
    in_item.chunk          = s_tdata[62:31];
    in_item.byte_count     = s_tdata[65:63];
    in_item.last           = s_tlast;
  end

  cfsh_round u_round (
    .item (a_item),
    .acc  (acc),
    .hash (round_hash)
  );

  cfsh_avalanche u_avalanche (
    .h_in  (b_hash),
    .h_out (aval_hash)
  );

  // Each stage frees up when empty or when its word moves on.
  assign out_free = !m_tvalid || m_tready;
  assign b_fire   = b_valid && out_free;
  assign b_free   = !b_valid || out_free;
  assign a_out_ok = a_valid && (!a_item.last || b_free);
  assign s_tready = !a_valid || a_out_ok;
  assign s_fire   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid  <= 1'b0;
      b_valid  <= 1'b0;
      m_tvalid <= 1'b0;
      acc      <= '0;
    end else begin
      if (s_fire) begin
        a_valid <= 1'b1;
        a_item  <= in_item;
      end else if (a_out_ok) begin
        a_valid <= 1'b0;
      end

      if (a_out_ok) begin
        // drop the running hash once a message ends
        acc <= a_item.last ? '0 : round_hash;
      end

      if (a_out_ok && a_item.last) begin
        b_valid <= 1'b1;
        b_hash  <= round_hash;
      end else if (b_fire) begin
        b_valid <= 1'b0;
      end

      if (b_fire) begin
        m_tvalid <= 1'b1;
        m_tdata  <= aval_hash;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  `CFSH_ASSERT_NEXT(a_acc_cleared, a_out_ok && a_item.last, acc == '0, "accumulator not cleared after last word")
  `CFSH_ASSERT_NEXT(a_b_holds, b_valid && !out_free, b_valid && $stable(b_hash), "avalanche stage lost its word")
  `CFSH_ASSERT_NEXT(a_last_waits, a_valid && a_item.last && !b_free, a_valid && $stable(acc), "last word left while stage busy")
  `CFSH_ASSERT_NOW(a_mid_no_stall, a_valid && !a_item.last, a_out_ok, "word without last stalled")

endmodule

[design/cfsh_round.sv]
module cfsh_round (
  input  cfsh_pkg::item_t item,
  input  logic [31:0]     acc,
  output logic [31:0]     hash
);
  import cfsh_pkg::*;

  logic [2:0]  cnt_sat;
  logic [31:0] h0;
  logic [31:0] hw0;
  logic [31:0] hw1;
  logic [31:0] b0;
  logic [31:0] b2;
  logic [31:0] f1;
  logic [31:0] f2;
  logic [31:0] full_h;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] t3;
  logic [31:0] three_h;
  logic [31:0] w2;
  logic [31:0] two_h;
  logic [31:0] o1;
  logic [31:0] o2;
  logic [31:0] one_h;

  always_comb begin
    cnt_sat = item.byte_count[2] ? COUNT_FULL : item.byte_count;
    h0      = item.first ? {1'b0, item.message_length} : acc;
    hw0     = half_word(item.chunk[15:0]);
    hw1     = half_word(item.chunk[31:16]);
    b0      = fold_ext(item.chunk[7:0]);
    b2      = fold_ext(item.chunk[23:16]);

    // main round
    f1     = h0 + hw0;
    f2     = (f1 << 16) ^ ((hw1 << 11) ^ f1);
    full_h = f2 + (f2 >> 11);

    // three-byte tail
    t1      = h0 + hw0;
    t2      = t1 ^ (t1 << 16);
    t3      = t2 ^ (b2 << 18);
    three_h = t3 + (t3 >> 11);

    // two-byte tail
    w2    = t1 ^ (t1 << 11);
    two_h = w2 + (w2 >> 17);

    // one-byte tail
    o1    = h0 + b0;
    o2    = o1 ^ (o1 << 10);
    one_h = o2 + (o2 >> 1);

    hash = h0;
    if (cnt_sat == COUNT_FULL) begin
      hash = full_h;
    end else if (item.last) begin
      case (cnt_sat)
        COUNT_THREE: hash = three_h;
        COUNT_TWO:   hash = two_h;
        COUNT_ONE:   hash = one_h;
        default:     hash = h0;
      endcase
    end
  end

endmodule

[design/cfsh_avalanche.sv]
module cfsh_avalanche (
  input  logic [31:0] h_in,
  output logic [31:0] h_out
);
  import cfsh_pkg::*;

  logic [31:0] s1;
  logic [31:0] s2;
  logic [31:0] s3;
  logic [31:0] s4;
  logic [31:0] s5;

  always_comb begin
    s1    = h_in ^ (h_in << 3);
    s2    = s1 + (s1 >> 5);
    s3    = s2 ^ (s2 << 4);
    s4    = s3 + (s3 >> 17);
    s5    = s4 ^ (s4 << 25);
    h_out = s5 + (s5 >> 6);
  end

endmodule
